[sv/round_robin_task_scheduler_unit_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RRTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RRTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

[sv/rrts_pkg.sv]
// Shared constants and types of the round-robin task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int PID_BITS  = 16;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int CTR_W     = PID_BITS + 1;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;

	// Command kinds
	localparam logic [KIND_W-1:0] K_CREATE = 3'd0;
	localparam logic [KIND_W-1:0] K_START  = 3'd1;
	localparam logic [KIND_W-1:0] K_YIELD  = 3'd2;
	localparam logic [KIND_W-1:0] K_EXIT   = 3'd3;
	localparam logic [KIND_W-1:0] K_SCHED  = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_PIDS = 2'd3;

	// Control from the sequencer to the slot picker
	typedef struct packed {
		logic                clear;
		logic                step;
		logic [SLOT_W-1:0]   slot;
		logic [PID_BITS-1:0] pid;
		logic [PID_BITS-1:0] floor_pid;
		logic [PID_BITS-1:0] target;
	} pick_ctl_t;

	// Running best candidates collected over one scan
	typedef struct packed {
		logic                any_vld;
		logic [SLOT_W-1:0]   any_slot;
		logic [PID_BITS-1:0] any_pid;
		logic                above_vld;
		logic [SLOT_W-1:0]   above_slot;
		logic [PID_BITS-1:0] above_pid;
		logic                match_vld;
		logic [SLOT_W-1:0]   match_slot;
	} pick_res_t;

endpackage

`default_nettype wire

[sv/rrts_if.sv]
// Command and response channel interfaces of the scheduler.
`timescale 1ns / 1ps
`default_nettype none

interface rrts_cmd_if import rrts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [PID_BITS-1:0] target_pid;

	modport source (output valid, kind, target_pid, input ready);
	modport sink   (input valid, kind, target_pid, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PID_BITS-1:0] new_pid;
	logic [PID_BITS-1:0] running_pid;
	logic [CNT_W-1:0]    task_count;
	logic [CNT_W-1:0]    ready_count;

	modport source (output valid, status, new_pid, running_pid, task_count, ready_count,
		input ready);
	modport sink   (input valid, status, new_pid, running_pid, task_count, ready_count,
		output ready);
endinterface

`default_nettype wire

[sv/rrts_pick.sv]
// Slot picker: folds one scanned slot per cycle into the best candidates.
`timescale 1ns / 1ps
`default_nettype none

module rrts_pick import rrts_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pick_ctl_t ctl,
	output pick_res_t      res
);

	pick_res_t res_q;

	// Track lowest ready pid, lowest ready pid above the floor, and the target match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q.any_vld   <= 1'b0;
			res_q.above_vld <= 1'b0;
			res_q.match_vld <= 1'b0;
		end else if (ctl.clear) begin
			res_q.any_vld   <= 1'b0;
			res_q.above_vld <= 1'b0;
			res_q.match_vld <= 1'b0;
		end else if (ctl.step) begin
			if (!res_q.any_vld || ctl.pid < res_q.any_pid) begin
				res_q.any_vld  <= 1'b1;
				res_q.any_slot <= ctl.slot;
				res_q.any_pid  <= ctl.pid;
			end
			if (ctl.pid > ctl.floor_pid && (!res_q.above_vld || ctl.pid < res_q.above_pid)) begin
				res_q.above_vld  <= 1'b1;
				res_q.above_slot <= ctl.slot;
				res_q.above_pid  <= ctl.pid;
			end
			if (!res_q.match_vld && ctl.pid == ctl.target) begin
				res_q.match_vld  <= 1'b1;
				res_q.match_slot <= ctl.slot;
			end
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

[sv/round_robin_task_scheduler_unit.sv]
// Round-robin task scheduler: top level with slot table, scan sequencer and response register.
//
// Keeps MAX_TASKS task slots; used and running flags sit in flip-flops, the pid of each
// slot sits in a synchronous RAM with a registered read. Every command yields
// exactly one response transaction carrying the status, the pid handed out by create,
// the current pid and the task and ready counts after the command. Create, and any
// command that is a no-op from the start (yield or exit with no current task, schedule
// with one, unknown kinds), go straight from acceptance to the decide state. Start,
// yield, exit and schedule otherwise walk the pid RAM one slot per cycle, then pass
// through a drain state for the registered RAM read before they decide. One
// command is in work at a time; a finished response waits in the output register while
// the next command is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "round_robin_task_scheduler_unit_macros.svh"

module round_robin_task_scheduler_unit import rrts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rrts_cmd_if.sink  cmd,
	rrts_rsp_if.source rsp
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0]           state_q;
	logic [MAX_TASKS-1:0] used_q, running_q;
	logic                 have_q;
	logic [SLOT_W-1:0]    cur_q;
	logic [PID_BITS-1:0]  cur_pid_q;
	logic [CNT_W-1:0]     task_cnt_q, ready_cnt_q;
	logic [CTR_W-1:0]     ctr_q;
	logic [KIND_W-1:0]    kind_q;
	logic [PID_BITS-1:0]  target_q;
	logic [SLOT_W-1:0]    idx_q;

	logic                 vld_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [PID_BITS-1:0]  pid_s1;

	logic [PID_BITS-1:0]  pid_mem [MAX_TASKS];

	logic                 rsp_vld_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [PID_BITS-1:0]  rsp_new_pid_q, rsp_run_pid_q;
	logic [CNT_W-1:0]     rsp_task_q, rsp_ready_q;

	logic                 cmd_fire, dec_fire, go_scan;
	logic                 full;
	logic [SLOT_W-1:0]    free_slot;
	pick_ctl_t            pick_ctl;
	pick_res_t            pick_res;

	logic [MAX_TASKS-1:0] nxt_used, nxt_run;
	logic                 nxt_have;
	logic [SLOT_W-1:0]    nxt_cur;
	logic [PID_BITS-1:0]  nxt_cur_pid;
	logic [CNT_W-1:0]     nxt_task, nxt_ready;
	logic [CTR_W-1:0]     nxt_ctr;
	logic [STATUS_W-1:0]  res_status;
	logic [PID_BITS-1:0]  res_new_pid;
	logic                 mem_we;
	logic [SLOT_W-1:0]    yld_slot;
	logic [PID_BITS-1:0]  yld_pid;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign dec_fire  = (state_q == S_DECIDE) && (!rsp_vld_q || rsp.ready);

	// Commands that need a walk over the pid table
	always_comb begin
		case (cmd.kind)
			K_START: go_scan = 1'b1;
			K_YIELD: go_scan = have_q;
			K_EXIT:  go_scan = have_q;
			K_SCHED: go_scan = !have_q;
			default: go_scan = 1'b0;
		endcase
	end

	// Lowest free slot
	always_comb begin
		full      = &used_q;
		free_slot = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (!used_q[i]) free_slot = SLOT_W'(i);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						idx_q   <= '0;
						state_q <= go_scan ? S_SCAN : S_DECIDE;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (idx_q == SLOT_W'(MAX_TASKS - 1)) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (dec_fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch the command
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			kind_q   <= cmd.kind;
			target_q <= cmd.target_pid;
		end
	end

	// Pid RAM: write on create, registered read during the scan
	always_ff @(posedge clk) begin
		if (mem_we) pid_mem[free_slot] <= ctr_q[PID_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		pid_s1  <= pid_mem[idx_q];
		slot_s1 <= idx_q;
	end

	// Feed ready slots to the picker
	always_comb begin
		pick_ctl.clear     = cmd_fire;
		pick_ctl.step      = vld_s1 && used_q[slot_s1] && !running_q[slot_s1];
		pick_ctl.slot      = slot_s1;
		pick_ctl.pid       = pid_s1;
		pick_ctl.floor_pid = cur_pid_q;
		pick_ctl.target    = target_q;
	end

	rrts_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pick_ctl),
		.res    (pick_res)
	);

	// Yield target: next pid above current, else wrap to the lowest
	assign yld_slot = pick_res.above_vld ? pick_res.above_slot : pick_res.any_slot;
	assign yld_pid  = pick_res.above_vld ? pick_res.above_pid  : pick_res.any_pid;

	// Work out the command's effect
	always_comb begin
		nxt_used    = used_q;
		nxt_run     = running_q;
		nxt_have    = have_q;
		nxt_cur     = cur_q;
		nxt_cur_pid = cur_pid_q;
		nxt_task    = task_cnt_q;
		nxt_ready   = ready_cnt_q;
		nxt_ctr     = ctr_q;
		res_status  = ST_NONE;
		res_new_pid = '0;
		mem_we      = 1'b0;
		case (kind_q)
			K_CREATE: begin
				if (full) begin
					res_status = ST_FULL;
				end else if (ctr_q[PID_BITS]) begin
					res_status = ST_PIDS;
				end else begin
					nxt_used[free_slot] = 1'b1;
					nxt_run[free_slot]  = 1'b0;
					mem_we              = dec_fire;
					res_new_pid         = ctr_q[PID_BITS-1:0];
					nxt_ctr             = ctr_q + CTR_W'(1);
					nxt_task            = task_cnt_q + CNT_W'(1);
					nxt_ready           = ready_cnt_q + CNT_W'(1);
					res_status          = ST_DONE;
				end
			end
			K_START: begin
				if (pick_res.match_vld) begin
					nxt_run[pick_res.match_slot] = 1'b1;
					nxt_cur     = pick_res.match_slot;
					nxt_have    = 1'b1;
					nxt_cur_pid = target_q;
					nxt_ready   = ready_cnt_q - CNT_W'(1);
					res_status  = ST_DONE;
				end
			end
			K_YIELD: begin
				if (have_q && pick_res.any_vld && yld_slot != cur_q) begin
					nxt_run[cur_q]    = 1'b0;
					nxt_run[yld_slot] = 1'b1;
					nxt_cur           = yld_slot;
					nxt_cur_pid       = yld_pid;
					res_status        = ST_DONE;
				end
			end
			K_EXIT: begin
				if (have_q) begin
					nxt_used[cur_q] = 1'b0;
					nxt_run[cur_q]  = 1'b0;
					nxt_task        = task_cnt_q - CNT_W'(1);
					nxt_have        = 1'b0;
					nxt_cur         = '0;
					res_status      = ST_DONE;
					if (pick_res.any_vld) begin
						nxt_run[pick_res.any_slot] = 1'b1;
						nxt_cur     = pick_res.any_slot;
						nxt_cur_pid = pick_res.any_pid;
						nxt_have    = 1'b1;
						nxt_ready   = ready_cnt_q - CNT_W'(1);
					end
				end
			end
			K_SCHED: begin
				if (!have_q && pick_res.any_vld) begin
					nxt_run[pick_res.any_slot] = 1'b1;
					nxt_cur     = pick_res.any_slot;
					nxt_cur_pid = pick_res.any_pid;
					nxt_have    = 1'b1;
					nxt_ready   = ready_cnt_q - CNT_W'(1);
					res_status  = ST_DONE;
				end
			end
			default: res_status = ST_NONE;
		endcase
	end

	// Commit scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			running_q   <= '0;
			have_q      <= 1'b0;
			cur_q       <= '0;
			cur_pid_q   <= '0;
			task_cnt_q  <= '0;
			ready_cnt_q <= '0;
			ctr_q       <= CTR_W'(1);
		end else if (dec_fire) begin
			used_q      <= nxt_used;
			running_q   <= nxt_run;
			have_q      <= nxt_have;
			cur_q       <= nxt_cur;
			cur_pid_q   <= nxt_cur_pid;
			task_cnt_q  <= nxt_task;
			ready_cnt_q <= nxt_ready;
			ctr_q       <= nxt_ctr;
		end
	end

	// Response register: load on decide, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (dec_fire) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			rsp_status_q  <= res_status;
			rsp_new_pid_q <= res_new_pid;
			rsp_run_pid_q <= nxt_have ? nxt_cur_pid : '0;
			rsp_task_q    <= nxt_task;
			rsp_ready_q   <= nxt_ready;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.new_pid     = rsp_new_pid_q;
	assign rsp.running_pid = rsp_run_pid_q;
	assign rsp.task_count  = rsp_task_q;
	assign rsp.ready_count = rsp_ready_q;

	// Checks
	`RRTS_ASSERT_NOW(a_ready_le_tasks, 1'b1, ready_cnt_q <= task_cnt_q)
	`RRTS_ASSERT_NOW(a_current_is_running, have_q, used_q[cur_q] && running_q[cur_q])
	`RRTS_ASSERT_NEXT(a_cmd_starts_work, cmd_fire, state_q != S_IDLE)
	`RRTS_ASSERT_NEXT(a_decide_loads_rsp, dec_fire, rsp_vld_q)

endmodule

`default_nettype wire

[bench/sched_checker.sv]
// Response checker for the round-robin task scheduler: slot table model and field compare.
`timescale 1ns / 1ps
`default_nettype none

module sched_checker import rrts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rrts_cmd_if       cmd,
	rrts_rsp_if       rsp,
	output int        fail_count,
	output int        open_count
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PID_BITS-1:0] new_pid;
		logic [PID_BITS-1:0] running_pid;
		logic [CNT_W-1:0]    task_count;
		logic [CNT_W-1:0]    ready_count;
	} sched_reply_t;

	// Own copy of the task table
	logic                tab_used [MAX_TASKS];
	logic                tab_run  [MAX_TASKS];
	logic [PID_BITS-1:0] tab_pid  [MAX_TASKS];
	logic [CTR_W-1:0]    pid_next;
	logic                cur_valid;
	logic [SLOT_W-1:0]   cur_slot;
	sched_reply_t        awaited_replies [$];

	// Return the lowest-pid ready slot, optionally above a floor pid; -1 if none
	function automatic int lowest_ready(input logic [PID_BITS-1:0] floor_pid,
		input logic use_floor);
		int best;
		best = -1;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (tab_used[i] && !tab_run[i] && (!use_floor || tab_pid[i] > floor_pid)) begin
				if (best < 0 || tab_pid[i] < tab_pid[best])
					best = i;
			end
		end
		return best;
	endfunction

	// Make the lowest-pid ready task running and current
	function automatic logic promote_lowest();
		int s;
		s = lowest_ready('0, 1'b0);
		if (s < 0)
			return 1'b0;
		tab_run[s] = 1'b1;
		cur_slot   = SLOT_W'(s);
		cur_valid  = 1'b1;
		return 1'b1;
	endfunction

	// Apply one command to the table and return the response it must produce
	function automatic sched_reply_t predict_reply(input logic [KIND_W-1:0] kind,
		input logic [PID_BITS-1:0] target);
		sched_reply_t r;
		int s;
		r = '0;
		r.status = ST_NONE;
		case (kind)
			K_CREATE: begin
				s = -1;
				for (int i = MAX_TASKS - 1; i >= 0; i--)
					if (!tab_used[i])
						s = i;
				if (s < 0) begin
					r.status = ST_FULL;
				end else if (pid_next > CTR_W'({PID_BITS{1'b1}})) begin
					r.status = ST_PIDS;
				end else begin
					tab_used[s] = 1'b1;
					tab_run[s]  = 1'b0;
					tab_pid[s]  = pid_next[PID_BITS-1:0];
					r.new_pid   = pid_next[PID_BITS-1:0];
					pid_next    = pid_next + 1'b1;
					r.status    = ST_DONE;
				end
			end
			K_START: begin
				// Old current task stays running
				for (int i = 0; i < MAX_TASKS; i++) begin
					if (r.status != ST_DONE && tab_used[i] && !tab_run[i] &&
						tab_pid[i] == target) begin
						tab_run[i] = 1'b1;
						cur_slot   = SLOT_W'(i);
						cur_valid  = 1'b1;
						r.status   = ST_DONE;
					end
				end
			end
			K_YIELD: begin
				if (cur_valid) begin
					// Next ready pid above the current one, else wrap to the lowest
					s = lowest_ready(tab_pid[cur_slot], 1'b1);
					if (s < 0)
						s = lowest_ready('0, 1'b0);
					if (s >= 0 && s != int'(cur_slot)) begin
						tab_run[cur_slot] = 1'b0;
						tab_run[s]        = 1'b1;
						cur_slot          = SLOT_W'(s);
						r.status          = ST_DONE;
					end
				end
			end
			K_EXIT: begin
				if (cur_valid) begin
					tab_used[cur_slot] = 1'b0;
					tab_run[cur_slot]  = 1'b0;
					cur_valid          = 1'b0;
					cur_slot           = '0;
					void'(promote_lowest());
					r.status = ST_DONE;
				end
			end
			K_SCHED: begin
				if (!cur_valid && promote_lowest())
					r.status = ST_DONE;
			end
			default: ;
		endcase

		// Counts after the command
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (tab_used[i]) begin
				r.task_count++;
				if (!tab_run[i])
					r.ready_count++;
			end
		end
		r.running_pid = cur_valid ? tab_pid[cur_slot] : '0;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] expected,
		input logic [31:0] actual);
		if (actual !== expected) begin
			fail_count++;
			$error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
		end
	endtask

	// Predict on each command transaction, compare on each response transaction
	always @(posedge clk or negedge arst_n) begin
		sched_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				tab_used[i] = 1'b0;
				tab_run[i]  = 1'b0;
				tab_pid[i]  = '0;
			end
			pid_next   = CTR_W'(1);
			cur_valid  = 1'b0;
			cur_slot   = '0;
			awaited_replies.delete();
			fail_count = 0;
			open_count = 0;
		end else begin
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				awaited_replies.push_back(predict_reply(cmd.kind, cmd.target_pid));
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (awaited_replies.size() == 0) begin
					fail_count++;
					$error("response transaction with no command waiting");
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("new_pid", want.new_pid, rsp.new_pid);
					check_field("running_pid", want.running_pid, rsp.running_pid);
					check_field("task_count", want.task_count, rsp.task_count);
					check_field("ready_count", want.ready_count, rsp.ready_count);
				end
			end
			open_count = awaited_replies.size();
		end
	end

endmodule

`default_nettype wire

[bench/testbench.sv]
// Top of the scheduler testbench: clock, reset, command stimulus, response stalls, verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import rrts_pkg::*;

	localparam int RANDOM_ITEMS  = 1000;
	// Create/exit rounds of the closing back-to-back stretch
	localparam int DRAIN_ROUNDS  = 80;
	// Quiet wait after the drain, scaled from the longest command, which walks all MAX_TASKS slots
	localparam int SETTLE_CYCLES = 3 * (MAX_TASKS + 3);
	// Hang guard above the slowest run, with every gap and stall at its longest
	localparam int CYCLE_LIMIT   = 400_000;

	logic clk;
	logic arst_n;
	logic calm = 1'b0;
	int   fails;
	int   pending;
	int   creates_sent = 0;

	rrts_cmd_if cmd_ch ();
	rrts_rsp_if rsp_ch ();

	round_robin_task_scheduler_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	sched_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.rsp        (rsp_ch),
		.fail_count (fails),
		.open_count (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("testbench NOT OK");
		$finish;
	end

	// Stall the response side in random bursts; hold ready high once calm
	initial begin
		logic level;
		forever begin
			level = calm || ($urandom_range(0, 2) != 0);
			rsp_ch.ready <= level;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Drive one command and hold it until the transaction completes
	task automatic issue(input logic [KIND_W-1:0] kind, input logic [PID_BITS-1:0] pid);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= kind;
		cmd_ch.target_pid <= pid;
		if (kind == K_CREATE)
			creates_sent++;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
	endtask

	task automatic pause_sender(input int cycles);
		cmd_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Mostly pids near the recent creates, sometimes anything
	function automatic logic [PID_BITS-1:0] pick_target();
		int lo;
		if ($urandom_range(0, 3) == 0)
			return PID_BITS'($urandom());
		lo = (creates_sent > 24) ? creates_sent - 24 : 0;
		return PID_BITS'($urandom_range(creates_sent + 1, lo));
	endfunction

	initial begin
		int gap_odds;
		int roll;
		logic [KIND_W-1:0] kind;

		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.kind       <= K_CREATE;
		cmd_ch.target_pid <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: every command but create has no effect
		issue(K_YIELD, '0);
		issue(K_EXIT, '0);
		issue(K_SCHED, '0);
		issue(K_START, '0);
		issue(K_START, {PID_BITS{1'b1}});
		issue(K_SCHED + 3'd1, {PID_BITS{1'b1}});
		issue(K_SCHED + 3'd3, '0);
		// Tasks 1 to 4, then start one with nothing current
		repeat (4) issue(K_CREATE, '0);
		issue(K_START, PID_BITS'(3));
		issue(K_SCHED, '0);
		// Yield to the next pid above, then wrap to the lowest
		issue(K_YIELD, '0);
		issue(K_YIELD, '0);
		// Start beside a running task, then retry the now running one
		issue(K_START, PID_BITS'(2));
		issue(K_START, PID_BITS'(2));
		// Exit chain down to no ready task left
		issue(K_EXIT, '0);
		issue(K_EXIT, '0);
		issue(K_EXIT, '0);
		issue(K_YIELD, '0);
		issue(K_SCHED, '0);
		issue(K_CREATE, {PID_BITS{1'b1}});
		issue(K_SCHED, '0);
		issue(K_SCHED + 3'd2, '0);

		// Random commands with sender gaps that come and go in stretches
		gap_odds = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				gap_odds = $urandom_range(0, 2);
			if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
				pause_sender($urandom_range(1, 12));
			roll = $urandom_range(0, 99);
			if (roll < 28)
				kind = K_CREATE;
			else if (roll < 36)
				kind = K_START;
			else if (roll < 60)
				kind = K_YIELD;
			else if (roll < 78)
				kind = K_EXIT;
			else if (roll < 92)
				kind = K_SCHED;
			else
				kind = KIND_W'(K_SCHED + $urandom_range(1, 3));
			issue(kind, pick_target());
		end

		// Cycle tasks back to back: each exit hands over to the lowest-pid ready task
		calm <= 1'b1;
		issue(K_SCHED, pick_target());
		for (int n = 0; n < DRAIN_ROUNDS; n++) begin
			issue(K_CREATE, pick_target());
			issue(K_EXIT, pick_target());
			if (n % 4 == 3)
				issue(K_SCHED, pick_target());
		end
		cmd_ch.valid <= 1'b0;

		// Drain outstanding responses, then watch for stray ones
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
